// File: hw/rtl/hsse_pkg.sv
// Package: payload types, encoder command word, character slots and constants.
package hsse_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned CharW      = 7;
  localparam int unsigned LineW      = 7;
  localparam int unsigned SplitW     = 17;
  localparam int unsigned LimitW     = 16;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned NumSlots   = 13;
  localparam int unsigned SlotW      = 4;

  localparam logic [LineW-1:0]  LineBytesMax   = 7'd127;
  localparam logic [SplitW-1:0] SplitMax       = 17'd131071;
  localparam logic [LineW-1:0]  BytesPerLineRst = 7'd38;
  localparam logic [LimitW-1:0] StringLimitRst  = 16'd64000;

  // Register indexes on the configuration channel.
  localparam logic [CfgIdxW-1:0] RegBytesPerLine = 2'd0;
  localparam logic [CfgIdxW-1:0] RegStringLimit  = 2'd1;

  // ASCII codes.
  localparam logic [CharW-1:0] ChZero    = 7'h30;
  localparam logic [CharW-1:0] ChLowerA  = 7'h61;
  localparam logic [CharW-1:0] ChOpen    = 7'h3c;
  localparam logic [CharW-1:0] ChClose   = 7'h3e;
  localparam logic [CharW-1:0] ChNewline = 7'h0a;

  // Character slots of one byte's output, in emission order.
  localparam logic [SlotW-1:0] SlotOpen   = 4'd0;
  localparam logic [SlotW-1:0] SlotHi     = 4'd1;
  localparam logic [SlotW-1:0] SlotLo     = 4'd2;
  localparam logic [SlotW-1:0] SlotSplit0 = 4'd3;
  localparam logic [SlotW-1:0] SlotSplit1 = 4'd4;
  localparam logic [SlotW-1:0] SlotSplit2 = 4'd5;
  localparam logic [SlotW-1:0] SlotSplit3 = 4'd6;
  localparam logic [SlotW-1:0] SlotSplit4 = 4'd7;
  localparam logic [SlotW-1:0] SlotNl     = 4'd8;
  localparam logic [SlotW-1:0] SlotClose0 = 4'd9;
  localparam logic [SlotW-1:0] SlotClose1 = 4'd10;
  localparam logic [SlotW-1:0] SlotClose2 = 4'd11;
  localparam logic [SlotW-1:0] SlotClose3 = 4'd12;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             end_of_buffer;
  } in_t;

  typedef struct packed {
    logic [CharW-1:0] char_out;
    logic             last_of_run;
  } out_t;

  typedef struct packed {
    logic [LineW-1:0]  bytes_per_line;
    logic [LimitW-1:0] string_limit;
  } cfg_t;

  // One classified byte, as handed from front to back.
  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             open_str;
    logic             split;
    logic             newline;
    logic             close_str;
  } cmd_t;

  localparam int unsigned CmdW = $bits(cmd_t);

  function automatic logic [CharW-1:0] hex_char(input logic [3:0] nib);
    logic [CharW-1:0] c;
    if (nib < 4'd10) begin
      c = ChZero + {3'd0, nib};
    end else begin
      c = ChLowerA + {3'd0, nib} - 7'd10;
    end
    return c;
  endfunction

  function automatic logic [NumSlots-1:0] cmd_mask(input cmd_t cmd);
    logic [NumSlots-1:0] m;
    m = '0;
    m[SlotOpen]   = cmd.open_str;
    m[SlotHi]     = 1'b1;
    m[SlotLo]     = 1'b1;
    m[SlotSplit0] = cmd.split;
    m[SlotSplit1] = cmd.split;
    m[SlotSplit2] = cmd.split;
    m[SlotSplit3] = cmd.split;
    m[SlotSplit4] = cmd.split;
    m[SlotNl]     = cmd.newline;
    m[SlotClose0] = cmd.close_str;
    m[SlotClose1] = cmd.close_str;
    m[SlotClose2] = cmd.close_str;
    m[SlotClose3] = cmd.close_str;
    return m;
  endfunction

  function automatic logic [CharW-1:0] slot_char(input logic [SlotW-1:0] slot,
                                                 input logic [ByteW-1:0] b);
    logic [CharW-1:0] c;
    unique case (slot)
      SlotOpen:   c = ChOpen;
      SlotHi:     c = hex_char(b[7:4]);
      SlotLo:     c = hex_char(b[3:0]);
      SlotSplit0: c = ChZero;
      SlotSplit1: c = ChZero;
      SlotSplit2: c = ChClose;
      SlotSplit3: c = ChNewline;
      SlotSplit4: c = ChOpen;
      SlotNl:     c = ChNewline;
      SlotClose0: c = ChZero;
      SlotClose1: c = ChZero;
      SlotClose2: c = ChClose;
      SlotClose3: c = ChNewline;
      default:    c = ChZero;
    endcase
    return c;
  endfunction

endpackage

// File: hw/rtl/hsse_front.sv
// Front end: configuration registers, line and split counters, byte classification.
module hsse_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [hsse_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [hsse_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                             accept_i,
  input  hsse_pkg::in_t                    in_data_i,
  output hsse_pkg::cmd_t                   cmd_o
);
  import hsse_pkg::*;

  cfg_t              cfg_q;
  logic [LineW-1:0]  line_q, line_d;
  logic [SplitW-1:0] split_q, split_d;
  logic              start_q, start_d;

  logic [LineW-1:0]  line_base, line_inc;
  logic [SplitW-1:0] split_base, split_inc;
  logic              line_end, do_split, eob;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bytes_per_line <= BytesPerLineRst;
      cfg_q.string_limit   <= StringLimitRst;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == RegBytesPerLine) begin
        cfg_q.bytes_per_line <= cfg_data_i[LineW-1:0];
      end else if (cfg_index_i == RegStringLimit) begin
        cfg_q.string_limit <= cfg_data_i[LimitW-1:0];
      end
    end
  end

  always_comb begin
    eob        = in_data_i.end_of_buffer;
    // Buffer start clears both counts before this byte is counted.
    line_base  = start_q ? '0 : line_q;
    split_base = start_q ? '0 : split_q;
    line_inc   = (line_base < LineBytesMax) ? line_base + 1'b1 : line_base;
    split_inc  = (split_base < SplitMax) ? split_base + 1'b1 : split_base;
    line_end   = (line_inc >= cfg_q.bytes_per_line) || eob;
    do_split   = line_end && (split_inc >= {1'b0, cfg_q.string_limit});

    cmd_o.data_byte = in_data_i.data_byte;
    cmd_o.open_str  = start_q;
    cmd_o.split     = do_split;
    cmd_o.newline   = line_end && !do_split && !eob;
    cmd_o.close_str = eob;

    if (eob) begin
      start_d = 1'b1;
      line_d  = '0;
      split_d = '0;
    end else begin
      start_d = 1'b0;
      line_d  = line_end ? '0 : line_inc;
      split_d = do_split ? '0 : split_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 1'b1;
      line_q  <= '0;
      split_q <= '0;
    end else if (accept_i) begin
      start_q <= start_d;
      line_q  <= line_d;
      split_q <= split_d;
    end
  end

endmodule

// File: hw/rtl/hsse_fifo.sv
// Small register queue of classified bytes between front and back.
module hsse_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  hsse_pkg::cmd_t wr_data_i,
  output logic           full_o,
  input  logic           rd_i,
  output hsse_pkg::cmd_t rd_data_o,
  output logic           empty_o
);
  import hsse_pkg::*;

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam logic [CntW-1:0]  DepthCnt = CntW'(Depth);

  cmd_t             mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_wr, do_rd;

  assign full_o    = (count_q == DepthCnt);
  assign empty_o   = (count_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == LastAddr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == LastAddr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/hsse_back.sv
// Back end: walks the character slots of each command, one character per cycle while pop keeps taking them.
module hsse_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  hsse_pkg::cmd_t cmd_i,
  input  logic           cmd_empty_i,
  output logic           cmd_pop_o,
  output hsse_pkg::out_t out_data_o,
  output logic           empty_o,
  input  logic           pop_i
);
  import hsse_pkg::*;

  logic [NumSlots-1:0] mask_q, mask_d, rest;
  logic [ByteW-1:0]    byte_q, byte_d;
  logic [SlotW-1:0]    sel;
  logic                active, emit, take, load, out_valid_q;
  out_t                out_q;

  always_comb begin
    sel = '0;
    // Lowest pending slot wins: scan downward so the last hit is the lowest.
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        sel = SlotW'(i);
      end
    end
  end

  assign rest      = mask_q & (mask_q - 1'b1);
  assign active    = (mask_q != '0);
  assign take      = pop_i && out_valid_q;
  assign emit      = active && (!out_valid_q || take);
  assign load      = !active || (emit && (rest == '0));
  assign cmd_pop_o = load && !cmd_empty_i;

  always_comb begin
    mask_d = mask_q;
    byte_d = byte_q;
    if (load) begin
      mask_d = cmd_empty_i ? '0 : cmd_mask(cmd_i);
      byte_d = cmd_i.data_byte;
    end else if (emit) begin
      mask_d = rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q <= mask_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    if (emit) begin
      out_q.char_out    <= slot_char(sel, byte_q);
      out_q.last_of_run <= (rest == '0);
    end
  end

  assign out_data_o = out_q;
  assign empty_o    = !out_valid_q;

endmodule

// File: hw/rtl/hex_string_stream_encoder.sv
// Top level: hex string stream encoder, front end, command queue and back end.
//
// Usage
//   Input channel: drive in_data_i (data_byte, end_of_buffer) and raise push;
//   a byte is taken at a clock edge where push is high and full is low. Mark
//   the last byte of each buffer with end_of_buffer.
//   Result channel: while empty is low, out_data_o holds the oldest character
//   (char_out, last_of_run); raise pop to take it. last_of_run marks the final
//   character that one input byte causes.
//   Configuration channel: cfg_valid_i with cfg_index_i and cfg_data_i; the
//   block is always ready. Index 0 is bytes_per_line, index 1 string_limit;
//   other indexes are dropped. Write only while the block is idle.
// Timing
//   A byte's first character passes the command queue and the slot mask
//   before it reaches the output register. Each byte yields 2 to 12
//   characters; the back end emits one per cycle while pop keeps taking
//   them, and the queue takes new bytes meanwhile until it is full.
// Reset and stalls
//   Reset restores the register defaults (38 and 64000), empties the queue
//   and arms the '<' for the next buffer. When pop stays low, the output
//   register holds, the back end stops, the queue fills and full rises.
module hex_string_stream_encoder #(
  parameter int unsigned FifoDepth = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  hsse_pkg::in_t                 in_data_i,
  output logic                          empty,
  input  logic                          pop,
  output hsse_pkg::out_t                out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [hsse_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [hsse_pkg::CfgDataW-1:0] cfg_data_i
);
  import hsse_pkg::*;

  cmd_t front_cmd, head_cmd;
  logic accept, q_empty, q_pop;

  // Configuration writes are always accepted.
  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;

  hsse_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .in_data_i   (in_data_i),
    .cmd_o       (front_cmd)
  );

  // Decouple classification from character emission.
  hsse_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (push),
    .wr_data_i (front_cmd),
    .full_o    (full),
    .rd_i      (q_pop),
    .rd_data_o (head_cmd),
    .empty_o   (q_empty)
  );

  hsse_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (head_cmd),
    .cmd_empty_i (q_empty),
    .cmd_pop_o   (q_pop),
    .out_data_o  (out_data_o),
    .empty_o     (empty),
    .pop_i       (pop)
  );

endmodule

// File: sim/tb_top.sv
// Testbench for the hex string stream encoder: directed and random buffers, checked per character.
`timescale 1ns / 100ps

module tb_top;
  import hsse_pkg::*;

  localparam int unsigned ClkPeriod  = 10;
  // Longest stretch without any transaction before the run is declared hung.
  localparam int unsigned StallLimit = 2000;
  // Cycles to keep watching the result side once nothing is expected.
  localparam int unsigned TailCycles = 16;
  localparam int unsigned MaxReports = 10;

  // Configuration indexes that hold no register; writes to them must be dropped.
  localparam logic [CfgIdxW-1:0] RegSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSpareB = 2'd3;

  // Bench's own view of the text format.
  localparam string       HexDigits  = "0123456789abcdef";
  localparam string       CloseText  = "00>\n";
  localparam logic [6:0]  AsciiOpen  = 7'h3c;
  localparam logic [6:0]  AsciiLf    = 7'h0a;
  localparam logic [6:0]  LineSat    = 7'd127;
  localparam logic [16:0] SplitSat   = 17'd131071;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                push;
  logic                full;
  in_t                 in_data_i;
  logic                empty;
  logic                pop;
  out_t                out_data_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  // Shadow of the encoder: registers and running counters, as after reset.
  logic [6:0]  shadow_bpl   = 7'd38;
  logic [15:0] shadow_limit = 16'd64000;
  logic [6:0]  line_count   = '0;
  logic [16:0] split_count  = '0;
  logic        open_pending = 1'b1;

  // Characters still owed by the encoder, oldest first.
  out_t expected_chars[$];

  int unsigned fail_count   = 0;
  int unsigned idle_cycles  = 0;
  int unsigned tx_calm_left = 0;
  int unsigned rx_calm_left = 0;

  hex_string_stream_encoder uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_data_i   (in_data_i),
    .empty       (empty),
    .pop         (pop),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Draw the wait before the next transaction. Now and then enter a calm
  // stretch in which the side does not hold off at all.
  function automatic int unsigned draw_wait(inout int unsigned calm_left);
    int unsigned n;
    n = 0;
    if (calm_left != 0) begin
      calm_left--;
    end else begin
      n = $urandom_range(0, 15);
      if ($urandom_range(0, 9) == 0) begin
        calm_left = $urandom_range(10, 40);
      end
    end
    return n;
  endfunction

  // Work out the text one accepted byte produces and advance the shadow
  // counters. The opening '<' comes first on a fresh buffer; a line end may
  // add a split ("00>\n<") or a plain newline; the buffer's last byte always
  // adds the closing "00>\n". Only the final character carries last_of_run.
  task automatic predict_chars(input in_t item);
    logic [6:0] chars[$];
    out_t       entry;
    if (open_pending) begin
      chars.push_back(AsciiOpen);
      open_pending = 1'b0;
      line_count   = '0;
      split_count  = '0;
    end
    chars.push_back(7'(HexDigits[item.data_byte[7:4]]));
    chars.push_back(7'(HexDigits[item.data_byte[3:0]]));

    // Both counters saturate rather than wrap.
    if (line_count != LineSat) line_count++;
    if (split_count != SplitSat) split_count++;

    // A zero bytes_per_line ends a line on every byte; a zero string_limit
    // splits at every line end. Both fall out of the unsigned compares.
    if (line_count >= shadow_bpl || item.end_of_buffer) begin
      if (split_count >= {1'b0, shadow_limit}) begin
        for (int k = 0; k < CloseText.len(); k++) chars.push_back(7'(CloseText[k]));
        chars.push_back(AsciiOpen);
        split_count = '0;
      end else if (!item.end_of_buffer) begin
        chars.push_back(AsciiLf);
      end
      line_count = '0;
    end

    if (item.end_of_buffer) begin
      for (int k = 0; k < CloseText.len(); k++) chars.push_back(7'(CloseText[k]));
      open_pending = 1'b1;
      line_count   = '0;
      split_count  = '0;
    end

    foreach (chars[k]) begin
      entry.char_out    = chars[k];
      entry.last_of_run = (k == chars.size() - 1);
      expected_chars.push_back(entry);
    end
  endtask

  // Offer one byte after a random hold-off, wait for the transaction and
  // record what it must produce. Leave push high so a back-to-back byte
  // follows without a bubble.
  task automatic send_byte(input logic [7:0] value, input logic is_last);
    in_t         item;
    int unsigned gap;
    item.data_byte     = value;
    item.end_of_buffer = is_last;
    gap = draw_wait(tx_calm_left);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_data_i <= item;
    push      <= 1'b1;
    do @(posedge clk_i); while (full);
    predict_chars(item);
  endtask

  // Send one whole buffer, marking its last byte.
  task automatic send_bytes(input logic [7:0] data_bytes[$]);
    foreach (data_bytes[k]) send_byte(data_bytes[k], k == data_bytes.size() - 1);
  endtask

  // Drop push and wait until every owed character has been taken.
  task automatic drain();
    push <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
  endtask

  // Write both registers plus a spare index that must be ignored. The
  // unused upper bits of the bytes_per_line word carry random junk. Call
  // only while the encoder is idle.
  task automatic program_regs(input logic [6:0] bpl, input logic [15:0] limit);
    logic [CfgIdxW-1:0]  idx_seq[3];
    logic [CfgDataW-1:0] word_seq[3];
    idx_seq[0]  = RegBytesPerLine;
    word_seq[0] = {9'($urandom_range(0, 511)), bpl};
    idx_seq[1]  = ($urandom_range(0, 1) == 0) ? RegSpareA : RegSpareB;
    word_seq[1] = 16'($urandom_range(0, 65535));
    idx_seq[2]  = RegStringLimit;
    word_seq[2] = limit;
    for (int k = 0; k < 3; k++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx_seq[k];
      cfg_data_i  <= word_seq[k];
      do @(posedge clk_i); while (!cfg_ready_o);
      case (idx_seq[k])
        RegBytesPerLine: shadow_bpl   = word_seq[k][6:0];
        RegStringLimit:  shadow_limit = word_seq[k];
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Reset values of the registers: short buffers, no line break, no split.
  task automatic test_reset_defaults();
    logic [7:0] data_bytes[$];
    data_bytes = {8'h00, 8'hff};
    send_bytes(data_bytes);
    data_bytes = {8'h5a};
    send_bytes(data_bytes);
    drain();
  endtask

  // Limit of one: every line end splits, and a one-byte buffer yields the
  // longest run of characters, an empty final string included.
  task automatic test_split_every_byte();
    logic [7:0] data_bytes[$];
    program_regs(7'd1, 16'd1);
    data_bytes = {8'ha5};
    send_bytes(data_bytes);
    data_bytes = {8'h09, 8'h90, 8'h0a};
    send_bytes(data_bytes);
    drain();
  endtask

  // Zero in both registers acts as one line per byte and a split per line.
  task automatic test_zero_registers();
    logic [7:0] data_bytes[$];
    program_regs(7'd0, 16'd0);
    data_bytes = {8'ha0, 8'h3c, 8'h7e};
    send_bytes(data_bytes);
    drain();
  endtask

  // Two bytes per line, split after five: newlines, a split mid-buffer and
  // a last byte that ends a line without a newline.
  task automatic test_line_and_split_mix();
    logic [7:0] data_bytes[$];
    program_regs(7'd2, 16'd5);
    data_bytes = {8'h01, 8'h23, 8'h45, 8'h67, 8'h89, 8'hab, 8'hcd};
    send_bytes(data_bytes);
    drain();
  endtask

  // Largest register values: nothing but the open, the hex digits and the close.
  task automatic test_widest_settings();
    logic [7:0] data_bytes[$];
    program_regs(7'd127, 16'd65535);
    data_bytes = {8'hef, 8'h12};
    send_bytes(data_bytes);
    drain();
  endtask

  // One buffer longer than the widest line: the line end at byte 127 also
  // reaches the split limit, and the tail closes without a newline.
  task automatic test_long_line();
    logic [7:0] data_bytes[$];
    program_regs(7'd127, 16'd127);
    repeat (130) data_bytes.push_back(8'($urandom_range(0, 255)));
    send_bytes(data_bytes);
    drain();
  endtask

  // Random buffers of random content, one register setting per phase.
  // Mostly short buffers so lines, splits and closes come often.
  task automatic test_random_buffers();
    logic [7:0]  data_bytes[$];
    logic [6:0]  bpl;
    logic [15:0] limit;
    int unsigned sent;
    int unsigned len;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          bpl   = 7'($urandom_range(1, 6));
          limit = 16'($urandom_range(1, 12));
        end
        1: begin
          bpl   = 7'($urandom_range(0, 3));
          limit = 16'($urandom_range(0, 4));
        end
        2: begin
          bpl   = 7'($urandom_range(0, 127));
          limit = 16'($urandom_range(0, 65535));
        end
        default: begin
          bpl   = 7'($urandom_range(1, 10));
          limit = 16'($urandom_range(8, 40));
        end
      endcase
      program_regs(bpl, limit);
      sent = 0;
      while (sent < 22) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
        data_bytes.delete();
        repeat (len) data_bytes.push_back(8'($urandom_range(0, 255)));
        send_bytes(data_bytes);
        sent += len;
      end
      drain();
    end
  endtask

  // Take characters with a random stall after each transaction.
  initial begin : result_sink
    int unsigned stall;
    pop <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    pop <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        stall = draw_wait(rx_calm_left);
        if (stall != 0) begin
          pop <= 1'b0;
          repeat (stall) @(posedge clk_i);
          pop <= 1'b1;
        end
      end
    end
  end

  // Compare every character taken with the oldest one owed.
  always @(posedge clk_i) begin : char_checker
    out_t want;
    if (rst_ni && pop && !empty) begin
      if (expected_chars.size() == 0) begin
        fail_count++;
        if (fail_count <= MaxReports) begin
          $display("%0t: unexpected character: char %h last %b",
                   $realtime, out_data_o.char_out, out_data_o.last_of_run);
        end
      end else begin
        want = expected_chars.pop_front();
        if (out_data_o.char_out !== want.char_out ||
            out_data_o.last_of_run !== want.last_of_run) begin
          fail_count++;
          if (fail_count <= MaxReports) begin
            $display("%0t: char mismatch: expected char %h last %b, got char %h last %b",
                     $realtime, want.char_out, want.last_of_run,
                     out_data_o.char_out, out_data_o.last_of_run);
          end
        end
      end
    end
  end

  // Abort if no transaction of any kind happens for too long.
  always @(posedge clk_i) begin : watchdog
    if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("%0t: no transaction for %0d cycles", $realtime, StallLimit);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin : main_sequence
    rst_ni      <= 1'b0;
    push        <= 1'b0;
    in_data_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_split_every_byte();
    test_zero_registers();
    test_line_and_split_mix();
    test_widest_settings();
    test_long_line();
    test_random_buffers();

    // Watch for stray characters after the last one owed.
    drain();
    repeat (TailCycles) @(posedge clk_i);
    if (expected_chars.size() != 0) begin
      fail_count++;
      $display("%0d characters never arrived", expected_chars.size());
    end
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: hex_string_stream_encoder.f
hw/rtl/hsse_pkg.sv
hw/rtl/hsse_front.sv
hw/rtl/hsse_fifo.sv
hw/rtl/hsse_back.sv
hw/rtl/hex_string_stream_encoder.sv
sim/tb_top.sv
